// File: hdl/mpdf_pkg.sv
// ----------------------------------------------------------------------------
// mpdf_pkg
// Shared types, constants and the bytewise CRC-32 for the MPDU
// de-aggregation and FCS check block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpdf_pkg;

   localparam int BYTE_W   = 8;
   localparam int FMT_W    = 2;
   localparam int RATE_W   = 4;
   localparam int OFFS_W   = 22;
   localparam int CRC_W    = 32;
   localparam int COUNT_W  = 32;
   localparam int DLEN_W   = 14;
   localparam int DSHIFT_W = 32;

   localparam logic [FMT_W-1:0] FMT_LEGACY = 2'd0;
   localparam logic [FMT_W-1:0] FMT_HT     = 2'd1;
   localparam logic [FMT_W-1:0] FMT_VHT    = 2'd2;
   localparam logic [FMT_W-1:0] FMT_HT_AGG = 2'd3;

   localparam logic [RATE_W-1:0] LEGACY_RATE_LIMIT = 4'd8;
   localparam logic [DLEN_W-1:0] DELIM_BYTES       = 14'd4;

   localparam logic [CRC_W-1:0] CRC_INIT    = 32'hFFFF_FFFF;
   localparam logic [CRC_W-1:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_RESIDUE = 32'd558161692;

   typedef enum logic [5:0] {
      PH_DELIM = 6'b000001,
      PH_BODY  = 6'b000010,
      PH_PAD   = 6'b000100,
      PH_DONE  = 6'b001000,
      PH_WHOLE = 6'b010000,
      PH_SKIP  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [FMT_W-1:0]   out_format;
      logic [OFFS_W-1:0]  mpdu_start;
      logic [OFFS_W-1:0]  mpdu_length;
      logic               fcs_good;
      logic [COUNT_W-1:0] good_total;
   } result_type;

   typedef struct packed {
      logic out_valid;
      logic skid_valid;
   } obuf_status_type;

   function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [DLEN_W-1:0] delim_length(input logic [DSHIFT_W-1:0] ds);
      return {ds[3:2], ds[15:4]};
   endfunction

endpackage

`default_nettype wire

// File: hdl/mpdf_req_if.sv
// ----------------------------------------------------------------------------
// mpdf_req_if
// Byte channel carrying the decoded PSDU with its format and MCS.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpdf_req_if import mpdf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;
   logic [FMT_W-1:0]  frame_format;
   logic [RATE_W-1:0] rate_index;

   modport source (output valid, data_byte, last_byte, frame_format, rate_index,
                   input ready);
   modport sink (input valid, data_byte, last_byte, frame_format, rate_index,
                 output ready);
endinterface

`default_nettype wire

// File: hdl/mpdf_rsp_if.sv
// ----------------------------------------------------------------------------
// mpdf_rsp_if
// Result channel carrying one reported MPDU and its FCS status.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpdf_rsp_if import mpdf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FMT_W-1:0]   out_format;
   logic [OFFS_W-1:0]  mpdu_start;
   logic [OFFS_W-1:0]  mpdu_length;
   logic               fcs_good;
   logic [COUNT_W-1:0] good_total;

   modport source (output valid, out_format, mpdu_start, mpdu_length, fcs_good,
                   good_total, input ready);
   modport sink (input valid, out_format, mpdu_start, mpdu_length, fcs_good,
                 good_total, output ready);
endinterface

`default_nettype wire

// File: hdl/mpdf_step.sv
// ----------------------------------------------------------------------------
// mpdf_step
// Per-byte parser state: delimiter parsing, CRC-32 over each MPDU, padding,
// and the running count of good frames.
// ----------------------------------------------------------------------------
`default_nettype none

module mpdf_step import mpdf_pkg::*; #(
   parameter int PSDU_BYTES_MAX = 4194304
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic              last_byte,
   input  wire logic [FMT_W-1:0]  frame_format,
   input  wire logic [RATE_W-1:0] rate_index,
   output logic                   emit,
   output result_type             result
);

   localparam int POS_W  = $clog2(PSDU_BYTES_MAX + 1);
   localparam int WIDE_W = (POS_W > OFFS_W) ? POS_W : OFFS_W;

   phase_type            phase_ff, phase_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [DSHIFT_W-1:0]  dshift_ff, dshift_in;
   logic [DLEN_W-1:0]    left_ff, left_in;
   logic [CRC_W-1:0]     crc_ff, crc_in;
   logic                 eof_ff, eof_in;
   logic [FMT_W-1:0]     fmt_ff, fmt_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic                 first;
   phase_type            phase_cur;
   logic [DSHIFT_W-1:0]  dshift_cur, dshift_next;
   logic [DLEN_W-1:0]    left_cur, left_dec, left_inc;
   logic [CRC_W-1:0]     crc_cur, crc_next;
   logic                 eof_cur;
   logic [POS_W-1:0]     pos_inc;
   logic [WIDE_W-1:0]    pos_wide;
   logic [OFFS_W-1:0]    pos_end;
   logic [DLEN_W-1:0]    new_len, cur_len;
   logic [1:0]           pad_len;
   logic                 crc_ok;

   assign first       = (pos_ff == '0);
   assign fmt_in      = (accept && first) ? frame_format : fmt_ff;
   assign rate_in     = (accept && first) ? rate_index : rate_ff;
   assign dshift_cur  = first ? '0 : dshift_ff;
   assign left_cur    = first ? '0 : left_ff;
   assign crc_cur     = first ? CRC_INIT : crc_ff;
   assign eof_cur     = first ? 1'b0 : eof_ff;
   assign crc_next    = crc32_byte(crc_cur, data_byte);
   assign crc_ok      = ((~crc_next) == CRC_RESIDUE);
   assign dshift_next = {data_byte, dshift_cur[DSHIFT_W-1:BYTE_W]};
   assign left_inc    = left_cur + DLEN_W'(1);
   assign left_dec    = (left_cur != '0) ? left_cur - DLEN_W'(1) : '0;
   assign new_len     = delim_length(dshift_next);
   assign cur_len     = delim_length(dshift_cur);
   assign pad_len     = 2'd0 - cur_len[1:0];
   assign pos_inc     = pos_ff + POS_W'(1);
   assign pos_wide    = WIDE_W'(pos_inc);
   assign pos_end     = pos_wide[OFFS_W-1:0];

   always_comb begin
      if (!first) begin
         phase_cur = phase_ff;
      end else if (frame_format == FMT_VHT) begin
         phase_cur = PH_DELIM;
      end else if (frame_format == FMT_HT_AGG) begin
         phase_cur = PH_SKIP;
      end else begin
         phase_cur = PH_WHOLE;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      dshift_in = dshift_ff;
      left_in   = left_ff;
      crc_in    = crc_ff;
      eof_in    = eof_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      result    = '0;
      if (accept) begin
         phase_in  = phase_cur;
         dshift_in = dshift_cur;
         left_in   = left_cur;
         crc_in    = crc_cur;
         eof_in    = eof_cur;
         if (pos_ff >= POS_W'(PSDU_BYTES_MAX)) begin
            phase_in = PH_SKIP;
         end else begin
            pos_in = pos_inc;
            case (phase_cur)
               PH_WHOLE: begin
                  crc_in = crc_next;
                  if (last_byte) begin
                     count_in = count_ff + COUNT_W'(crc_ok);
                     if (!(fmt_in == FMT_LEGACY && rate_in >= LEGACY_RATE_LIMIT)) begin
                        emit               = 1'b1;
                        result.out_format  = fmt_in;
                        result.mpdu_start  = '0;
                        result.mpdu_length = pos_end;
                        result.fcs_good    = crc_ok;
                        result.good_total  = count_in;
                     end
                  end
               end
               PH_DELIM: begin
                  dshift_in = dshift_next;
                  left_in   = left_inc;
                  if (left_inc >= DELIM_BYTES) begin
                     eof_in = dshift_next[0];
                     if (new_len == '0) begin
                        left_in  = '0;
                        phase_in = dshift_next[0] ? PH_DONE : PH_DELIM;
                     end else begin
                        left_in  = new_len;
                        crc_in   = CRC_INIT;
                        phase_in = PH_BODY;
                     end
                  end
               end
               PH_BODY: begin
                  crc_in  = crc_next;
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     count_in           = count_ff + COUNT_W'(crc_ok);
                     emit               = 1'b1;
                     result.out_format  = FMT_VHT;
                     result.mpdu_start  = pos_end - OFFS_W'(cur_len);
                     result.mpdu_length = OFFS_W'(cur_len);
                     result.fcs_good    = crc_ok;
                     result.good_total  = count_in;
                     if (eof_cur) begin
                        phase_in = PH_DONE;
                     end else if (cur_len[1:0] != 2'd0) begin
                        left_in  = {{(DLEN_W-2){1'b0}}, pad_len};
                        phase_in = PH_PAD;
                     end else begin
                        phase_in = PH_DELIM;
                     end
                  end
               end
               PH_PAD: begin
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     phase_in = PH_DELIM;
                  end
               end
               default: begin
               end
            endcase
         end
         if (last_byte) begin
            phase_in  = PH_DELIM;
            pos_in    = '0;
            dshift_in = '0;
            left_in   = '0;
            crc_in    = CRC_INIT;
            eof_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DELIM;
         pos_ff    <= '0;
         dshift_ff <= '0;
         left_ff   <= '0;
         crc_ff    <= CRC_INIT;
         eof_ff    <= 1'b0;
         fmt_ff    <= '0;
         rate_ff   <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         dshift_ff <= dshift_in;
         left_ff   <= left_in;
         crc_ff    <= crc_in;
         eof_ff    <= eof_in;
         fmt_ff    <= fmt_in;
         rate_ff   <= rate_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/mpdf_obuf.sv
// ----------------------------------------------------------------------------
// mpdf_obuf
// Result register with a skid stage, so that input bytes keep flowing while
// a finished result waits on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mpdf_obuf import mpdf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  result_type   push_data,
   mpdf_rsp_if.source   rsp_bus,
   output obuf_status_type status
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop = out_valid_ff && rsp_bus.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.out_format  = out_data_ff.out_format;
   assign rsp_bus.mpdu_start  = out_data_ff.mpdu_start;
   assign rsp_bus.mpdu_length = out_data_ff.mpdu_length;
   assign rsp_bus.fcs_good    = out_data_ff.fcs_good;
   assign rsp_bus.good_total  = out_data_ff.good_total;

   assign status.out_valid  = out_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

`default_nettype wire

// File: hdl/mpdu_deaggregate_fcs_check_unit.sv
// ----------------------------------------------------------------------------
// mpdu_deaggregate_fcs_check_unit
// Takes one PSDU byte per cycle and reports each MPDU with its CRC-32 FCS
// status, except legacy frames at rate index 8 or more and aggregated HT
// frames. Throughput is one byte per cycle, set by the bytewise CRC and
// parser update; input stalls only while both the result register and the
// skid stage hold results. Synchronous reset clears the parser, the
// good-frame count and the output stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mpdu_deaggregate_fcs_check_unit import mpdf_pkg::*; #(
   parameter int PSDU_BYTES_MAX = 4194304
) (
   input  wire logic clock,
   input  wire logic reset,
   mpdf_req_if.sink   req_bus,
   mpdf_rsp_if.source rsp_bus
);

   logic            accept;
   logic            emit;
   result_type      result;
   obuf_status_type status;

   assign req_bus.ready = !status.skid_valid;
   assign accept        = req_bus.valid && req_bus.ready;

   mpdf_step #(
      .PSDU_BYTES_MAX(PSDU_BYTES_MAX)
   ) u_step (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_bus.data_byte),
      .last_byte   (req_bus.last_byte),
      .frame_format(req_bus.frame_format),
      .rate_index  (req_bus.rate_index),
      .emit        (emit),
      .result      (result)
   );

   mpdf_obuf u_obuf (
      .clock    (clock),
      .reset    (reset),
      .push     (emit),
      .push_data(result),
      .rsp_bus  (rsp_bus),
      .status   (status)
   );

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      status.skid_valid |-> status.out_valid)
      else $error("skid stage holds a result while the output register is empty");

   a_no_agg_format: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.out_format != FMT_HT_AGG))
      else $error("aggregated HT frame reported");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_bus.valid && req_bus.ready))
      else $error("output stages not cleared by reset");

endmodule

`default_nettype wire
